/* hdl/q2pp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package q2pp_pkg;

   // Number of CORDIC iterations; anything above the table length acts as the table length.
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int NUM_ITER     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int IDX_W        = $clog2(ATAN_ENTRIES);

   // Field widths.
   localparam int POS_W   = 32;
   localparam int QUAT_W  = 16;
   localparam int HEAD_W  = 16;
   localparam int PROD_W  = 2 * QUAT_W;
   // Forward vector in units of 2^-28; its magnitude stays at or below 2^32.
   localparam int FWD_W   = PROD_W + 2;
   // CORDIC datapath: gain of about 1.65 on a vector of length up to sqrt(2) * 2^32.
   localparam int CORD_W  = FWD_W + 2;
   // Angle accumulator in units of 2^-24 rad.
   localparam int ANGLE_W = 28;
   localparam int ROUND_SHIFT = 11;

   localparam logic signed [FWD_W-1:0]   FWD_ONE    = FWD_W'(1) << 28;
   localparam logic signed [ANGLE_W-1:0] HALF_PI    = ANGLE_W'(26353589);
   localparam logic signed [ANGLE_W-1:0] ROUND_BIAS = ANGLE_W'(1) << (ROUND_SHIFT - 1);
   localparam logic signed [HEAD_W-1:0]  PI_Q13     = HEAD_W'(25736);

   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  out_x;
      logic signed [POS_W-1:0]  out_y;
      logic signed [HEAD_W-1:0] heading;
   } rsp_type;

   // Contents of one CORDIC pipeline stage.
   typedef struct packed {
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [CORD_W-1:0]  vec_x;
      logic signed [CORD_W-1:0]  vec_y;
      logic signed [ANGLE_W-1:0] angle;
      logic                      is_zero;
   } cordic_type;

   // atan(2^-i) in units of 2^-24 rad, rounded to nearest.
   function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
      logic signed [ANGLE_W-1:0] val;
      case (idx)
         5'd0:    val = ANGLE_W'(13176795);
         5'd1:    val = ANGLE_W'(7778716);
         5'd2:    val = ANGLE_W'(4110060);
         5'd3:    val = ANGLE_W'(2086331);
         5'd4:    val = ANGLE_W'(1047214);
         5'd5:    val = ANGLE_W'(524117);
         5'd6:    val = ANGLE_W'(262123);
         5'd7:    val = ANGLE_W'(131069);
         5'd8:    val = ANGLE_W'(65536);
         5'd9:    val = ANGLE_W'(32768);
         5'd10:   val = ANGLE_W'(16384);
         5'd11:   val = ANGLE_W'(8192);
         5'd12:   val = ANGLE_W'(4096);
         5'd13:   val = ANGLE_W'(2048);
         5'd14:   val = ANGLE_W'(1024);
         5'd15:   val = ANGLE_W'(512);
         5'd16:   val = ANGLE_W'(256);
         5'd17:   val = ANGLE_W'(128);
         5'd18:   val = ANGLE_W'(64);
         5'd19:   val = ANGLE_W'(32);
         5'd20:   val = ANGLE_W'(16);
         5'd21:   val = ANGLE_W'(8);
         5'd22:   val = ANGLE_W'(4);
         5'd23:   val = ANGLE_W'(2);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* hdl/q2pp_fwd.sv */
`timescale 1ns / 1ps
`default_nettype none

module q2pp_fwd (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  enable,
   input  wire logic                  in_valid,
   input  wire q2pp_pkg::req_type     in_data,
   output logic                       out_valid,
   output q2pp_pkg::cordic_type       out_data
);

   // Stage one: the four quaternion products.
   logic                                   s1_valid_ff, s1_valid_in;
   logic signed [q2pp_pkg::POS_W-1:0]      s1_pos_x_ff, s1_pos_y_ff;
   logic signed [q2pp_pkg::PROD_W-1:0]     s1_yy_ff, s1_zz_ff, s1_xy_ff, s1_wz_ff;
   logic signed [q2pp_pkg::PROD_W-1:0]     s1_yy_in, s1_zz_in, s1_xy_in, s1_wz_in;

   // Stage two: the forward vector.
   logic                                   s2_valid_ff, s2_valid_in;
   logic signed [q2pp_pkg::POS_W-1:0]      s2_pos_x_ff, s2_pos_y_ff;
   logic signed [q2pp_pkg::FWD_W-1:0]      s2_fx_ff, s2_fy_ff, s2_fx_in, s2_fy_in;
   logic signed [q2pp_pkg::PROD_W:0]       sq_sum, cross_sum;

   // Stage three: quadrant pre-rotation.
   logic                                   s3_valid_ff, s3_valid_in;
   q2pp_pkg::cordic_type                   s3_data_ff, s3_data_in;

   assign s1_valid_in = in_valid;
   assign s2_valid_in = s1_valid_ff;
   assign s3_valid_in = s2_valid_ff;

   always_comb begin
      s1_yy_in = q2pp_pkg::PROD_W'(in_data.quat_y) * q2pp_pkg::PROD_W'(in_data.quat_y);
      s1_zz_in = q2pp_pkg::PROD_W'(in_data.quat_z) * q2pp_pkg::PROD_W'(in_data.quat_z);
      s1_xy_in = q2pp_pkg::PROD_W'(in_data.quat_x) * q2pp_pkg::PROD_W'(in_data.quat_y);
      s1_wz_in = q2pp_pkg::PROD_W'(in_data.quat_w) * q2pp_pkg::PROD_W'(in_data.quat_z);
   end

   always_comb begin
      sq_sum    = (q2pp_pkg::PROD_W+1)'(s1_yy_ff) + (q2pp_pkg::PROD_W+1)'(s1_zz_ff);
      cross_sum = (q2pp_pkg::PROD_W+1)'(s1_xy_ff) + (q2pp_pkg::PROD_W+1)'(s1_wz_ff);
      s2_fx_in  = q2pp_pkg::FWD_ONE - (q2pp_pkg::FWD_W'(sq_sum) <<< 1);
      s2_fy_in  = q2pp_pkg::FWD_W'(cross_sum) <<< 1;
   end

   // Vectors in the left half-plane are turned by a quarter turn so the
   // iterations only ever have to cover the right half-plane.
   always_comb begin
      s3_data_in.pos_x   = s2_pos_x_ff;
      s3_data_in.pos_y   = s2_pos_y_ff;
      s3_data_in.is_zero = (s2_fx_ff == '0) && (s2_fy_ff == '0);
      if (s2_fx_ff < 0) begin
         if (s2_fy_ff >= 0) begin
            s3_data_in.vec_x = q2pp_pkg::CORD_W'(s2_fy_ff);
            s3_data_in.vec_y = -q2pp_pkg::CORD_W'(s2_fx_ff);
            s3_data_in.angle = q2pp_pkg::HALF_PI;
         end else begin
            s3_data_in.vec_x = -q2pp_pkg::CORD_W'(s2_fy_ff);
            s3_data_in.vec_y = q2pp_pkg::CORD_W'(s2_fx_ff);
            s3_data_in.angle = -q2pp_pkg::HALF_PI;
         end
      end else begin
         s3_data_in.vec_x = q2pp_pkg::CORD_W'(s2_fx_ff);
         s3_data_in.vec_y = q2pp_pkg::CORD_W'(s2_fy_ff);
         s3_data_in.angle = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_pos_x_ff <= in_data.pos_x;
         s1_pos_y_ff <= in_data.pos_y;
         s1_yy_ff    <= s1_yy_in;
         s1_zz_ff    <= s1_zz_in;
         s1_xy_ff    <= s1_xy_in;
         s1_wz_ff    <= s1_wz_in;
         s2_pos_x_ff <= s1_pos_x_ff;
         s2_pos_y_ff <= s1_pos_y_ff;
         s2_fx_ff    <= s2_fx_in;
         s2_fy_ff    <= s2_fy_in;
         s3_data_ff  <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

`default_nettype wire

/* hdl/q2pp_cordic_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module q2pp_cordic_stage (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         enable,
   input  wire logic [q2pp_pkg::IDX_W-1:0]   stage_idx,
   input  wire logic                         in_valid,
   input  wire q2pp_pkg::cordic_type         in_data,
   output logic                              out_valid,
   output q2pp_pkg::cordic_type              out_data
);

   logic                                 valid_ff, valid_in;
   q2pp_pkg::cordic_type                 data_ff, data_in;
   logic signed [q2pp_pkg::CORD_W-1:0]   shift_x, shift_y;
   logic signed [q2pp_pkg::ANGLE_W-1:0]  step_angle;

   assign valid_in = in_valid;

   // One vectoring iteration: rotate towards the x axis, both updates from the old vector.
   always_comb begin
      shift_x    = in_data.vec_x >>> stage_idx;
      shift_y    = in_data.vec_y >>> stage_idx;
      step_angle = q2pp_pkg::atan_entry(stage_idx);
      data_in    = in_data;
      if (!in_data.vec_y[q2pp_pkg::CORD_W-1]) begin
         data_in.vec_x = in_data.vec_x + shift_y;
         data_in.vec_y = in_data.vec_y - shift_x;
         data_in.angle = in_data.angle + step_angle;
      end else begin
         data_in.vec_x = in_data.vec_x - shift_y;
         data_in.vec_y = in_data.vec_y + shift_x;
         data_in.angle = in_data.angle - step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* hdl/q2pp_round.sv */
`timescale 1ns / 1ps
`default_nettype none

module q2pp_round (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    enable,
   input  wire logic                    in_valid,
   input  wire q2pp_pkg::cordic_type    in_data,
   output logic                         out_valid,
   output q2pp_pkg::rsp_type            out_data
);

   logic                                    valid_ff, valid_in;
   q2pp_pkg::rsp_type                       data_ff, data_in;
   logic signed [q2pp_pkg::ANGLE_W-1:0]     biased;
   logic signed [q2pp_pkg::ANGLE_W-q2pp_pkg::ROUND_SHIFT-1:0] rounded;

   assign valid_in = in_valid;

   // Round half up to Q3.13, then fold minus pi and anything beyond onto plus pi; a zero vector gives zero.
   always_comb begin
      biased          = in_data.angle + q2pp_pkg::ROUND_BIAS;
      rounded         = biased[q2pp_pkg::ANGLE_W-1:q2pp_pkg::ROUND_SHIFT];
      data_in.out_x   = in_data.pos_x;
      data_in.out_y   = in_data.pos_y;
      if (in_data.is_zero) begin
         data_in.heading = '0;
      end else if ((rounded > $bits(rounded)'(q2pp_pkg::PI_Q13)) ||
                   (rounded <= -$bits(rounded)'(q2pp_pkg::PI_Q13))) begin
         data_in.heading = q2pp_pkg::PI_Q13;
      end else begin
         data_in.heading = rounded[q2pp_pkg::HEAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* hdl/q2pp_out_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module q2pp_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire q2pp_pkg::rsp_type    in_data,
   output logic                      pipe_enable,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output q2pp_pkg::rsp_type         rsp_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   q2pp_pkg::rsp_type    main_data_ff, main_data_in;
   q2pp_pkg::rsp_type    skid_data_ff, skid_data_in;
   logic                 push, pop;

   // The pipeline only moves while the skid entry is free, so a push never finds both full.
   assign pipe_enable = !skid_valid_ff;
   assign push        = in_valid && pipe_enable;
   assign pop         = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = in_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

endmodule

`default_nettype wire

/* hdl/quaternion_to_planar_pose_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                              Direction  Carries
// request   req_valid, req_stall, req_data     in         position and orientation quaternion
// response  rsp_valid, rsp_stall, rsp_data     out        position and heading in Q3.13 rad
//
// One pose enters per clock cycle while req_stall is low. It passes registered stages for the
// products, forward vector and quadrant pre-rotation, one per CORDIC iteration, one for rounding
// and one in the output register.
// Reset is synchronous and active high; it clears every valid bit, including those of both output entries.
// The whole pipeline advances together and halts only when the two-entry output buffer is full,
// which is a registered condition, so req_stall never depends combinationally on rsp_stall.

module quaternion_to_planar_pose_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire q2pp_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output q2pp_pkg::rsp_type        rsp_data
);

   logic                    pipe_enable;
   logic                    chain_valid [0:q2pp_pkg::NUM_ITER];
   q2pp_pkg::cordic_type    chain_data  [0:q2pp_pkg::NUM_ITER];
   logic                    round_valid;
   q2pp_pkg::rsp_type       round_data;

   // A request transfer happens whenever the pipeline is free to move.
   assign req_stall = !pipe_enable;

   // Forward vector from the quaternion and reduction to the right half-plane.
   q2pp_fwd u_fwd (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_enable),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   // Unrolled CORDIC in vectoring mode, one registered iteration per stage.
   for (genvar g = 0; g < q2pp_pkg::NUM_ITER; g++) begin : g_cordic
      q2pp_cordic_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_enable),
         .stage_idx (q2pp_pkg::IDX_W'(g)),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // Rounding of the accumulated angle to Q3.13 and the special cases.
   q2pp_round u_round (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_enable),
      .in_valid  (chain_valid[q2pp_pkg::NUM_ITER]),
      .in_data   (chain_data[q2pp_pkg::NUM_ITER]),
      .out_valid (round_valid),
      .out_data  (round_data)
   );

   // Output register with a skid entry to decouple the response stall.
   q2pp_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (round_valid),
      .in_data     (round_data),
      .pipe_enable (pipe_enable),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
